// File: src/srs_pkg.sv
// Shared types and constants for the sparse row store.
package srs_pkg;

    typedef enum logic [2:0] {
        OP_APPEND     = 3'd0,
        OP_OVERWRITE  = 3'd1,
        OP_ACCUMULATE = 3'd2,
        OP_READ       = 3'd3,
        OP_LOAD       = 3'd4,
        OP_PRODUCT    = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FILL,
        S_SCAN,
        S_HIT,
        S_APPEND,
        S_ROUND,
        S_RESP
    } state_t;

    typedef enum logic [0:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } reg_index_t;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    localparam int ACC_W = 72;
    localparam int VAL_W = 32;
    localparam int CNT_W = 9;

endpackage

// File: src/srs_mac.sv
// Shared multiply-accumulate unit with Q16.16 rounding and saturation.
module srs_mac
    import srs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctrl_t               ctrl,
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [VAL_W-1:0] b,
    output logic        [VAL_W-1:0] result,
    output logic                    sat
);

    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic        [ACC_W-1:0]   rnd;
    logic                      fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= a * b;
        end
    end

    // Round half up, then the result fits when the bits above bit 47 are a sign extension.
    assign rnd    = acc_reg + ACC_W'(32'h0000_8000);
    assign fits   = (&rnd[ACC_W-1:47]) || !(|rnd[ACC_W-1:47]);
    assign sat    = !fits;
    assign result = fits ? rnd[47:16] : (rnd[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

endmodule

// File: src/sparse_row_store_with_spmv.sv
// Top level of the sparse row store with row-times-vector product.
//
//  Channel   Signals                               Beat contents
//  s_        s_tvalid s_tready s_tdata s_tuser     one operation
//  m_        m_tvalid m_tready m_tdata m_tuser     one result
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data register write
//
// Errors, load and clear finish without touching the entry memory. Append reads the row's
// fill; overwrite, accumulate, read and products also scan the row: its entries are
// streamed one a cycle from the entry memory (separate read and write ports), and for
// products through the shared multiply-accumulate unit.
// Reset is asynchronous; row fill counts and vector elements come up as zero through
// valid bits, so no clearing pass is needed. A stalled result holds the block in its
// response state until the result register is free.
module sparse_row_store_with_spmv
    import srs_pkg::*;
#(
    parameter int MAX_ROWS        = 256,
    parameter int MAX_COLS        = 256,
    parameter int ENTRIES_PER_ROW = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // row_index[7:0], column_index[15:8], operand_value[47:16]
    input  logic [2:0]  s_tuser,    // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // result_value[31:0]
    output logic [2:0]  m_tuser,    // found[0], status[2:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int EPR   = ENTRIES_PER_ROW;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int VCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int FW    = $clog2(EPR + 1);
    localparam int IW    = (EPR > 1) ? $clog2(EPR) : 1;
    localparam int EDEP  = MAX_ROWS * EPR;
    localparam int EW    = (EDEP > 1) ? $clog2(EDEP) : 1;

    state_t                state_reg, state_next;
    op_t                   op_reg;
    logic [7:0]            row_reg;
    logic [7:0]            col_reg;
    logic [VAL_W-1:0]      val_reg;
    logic [CNT_W-1:0]      row_count_reg;
    logic [CNT_W-1:0]      col_count_reg;

    logic [MAX_ROWS-1:0]   row_vld_reg, row_vld_next;
    logic [MAX_COLS-1:0]   vec_vld_reg, vec_vld_next;
    logic [FW-1:0]         fill_mem [MAX_ROWS];
    logic [FW-1:0]         fill_q_reg;
    logic [FW-1:0]         fill_reg, fill_next;
    logic [VAL_W-1:0]      vec_mem [MAX_COLS];
    logic [VAL_W-1:0]      vec_q_reg;
    logic                  vec_ok_reg;
    logic [7:0]            ent_col_mem [EDEP];
    logic [VAL_W-1:0]      ent_val_mem [EDEP];
    logic [7:0]            ent_col_q_reg;
    logic [VAL_W-1:0]      ent_val_q_reg;

    logic [FW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  p1_vld_reg, p1_vld_next;
    logic [FW-1:0]         p1_idx_reg;
    logic                  p2_vld_reg, p2_vld_next;
    logic [VAL_W-1:0]      p2_val_reg;
    logic                  p3_vld_reg, p3_vld_next;
    logic [FW-1:0]         hit_idx_reg;
    logic [VAL_W-1:0]      hit_val_reg;

    logic [VAL_W-1:0]      res_val_reg, res_val_next;
    logic                  res_found_reg, res_found_next;
    status_t               res_st_reg, res_st_next;
    logic                  out_vld_reg, out_vld_next;
    logic [VAL_W-1:0]      out_val_reg;
    logic                  out_found_reg;
    status_t               out_st_reg;

    logic [15:0]           row_ext, col_ext, ecol_ext;
    logic [RW-1:0]         row_addr;
    logic [VCW-1:0]        col_addr, ecol_addr;
    logic                  row_ok, col_ok, ecol_in;
    logic                  issue, hit, pipe_empty, out_free;
    logic [EW-1:0]         ent_raddr, ent_waddr;
    logic                  ent_we;
    logic [VAL_W-1:0]      ent_wval;
    logic                  fill_we, vec_we, load_out;
    logic [VAL_W:0]        acc_sum;
    logic [VAL_W-1:0]      sat_sum;
    mac_ctrl_t             mac_ctrl;
    logic [VAL_W-1:0]      mac_b;
    logic [VAL_W-1:0]      mac_result;
    logic                  mac_sat;

    function automatic logic [EW-1:0] ent_addr(input logic [RW-1:0] r, input logic [IW-1:0] i);
        ent_addr = EW'(32'(r) * 32'(EPR) + 32'(i));
    endfunction

    assign row_ext   = 16'(row_reg);
    assign col_ext   = 16'(col_reg);
    assign ecol_ext  = 16'(ent_col_q_reg);
    assign row_addr  = row_ext[RW-1:0];
    assign col_addr  = col_ext[VCW-1:0];
    assign ecol_addr = ecol_ext[VCW-1:0];
    assign row_ok    = (16'(row_count_reg) > row_ext) && (16'(MAX_ROWS) > row_ext);
    assign col_ok    = (16'(col_count_reg) > col_ext) && (16'(MAX_COLS) > col_ext);
    assign ecol_in   = 16'(MAX_COLS) > ecol_ext;

    assign issue      = (state_reg == S_SCAN) && (rd_idx_reg < fill_reg);
    assign hit        = (state_reg == S_SCAN) && p1_vld_reg && (op_reg != OP_PRODUCT)
                        && (ent_col_q_reg == col_reg);
    assign pipe_empty = !p1_vld_reg && !p2_vld_reg && !p3_vld_reg;
    assign out_free   = !out_vld_reg || m_tready;

    assign acc_sum = {hit_val_reg[VAL_W-1], hit_val_reg} + {val_reg[VAL_W-1], val_reg};
    assign sat_sum = (acc_sum[VAL_W] != acc_sum[VAL_W-1])
                     ? (acc_sum[VAL_W] ? 32'h8000_0000 : 32'h7FFF_FFFF) : acc_sum[VAL_W-1:0];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_val_reg;
    assign m_tuser   = {out_st_reg, out_found_reg};

    assign mac_b = vec_ok_reg ? vec_q_reg : '0;

    srs_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a      (p2_val_reg),
        .b      (mac_b),
        .result (mac_result),
        .sat    (mac_sat)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (op_reg)
                    OP_NONE, OP_CLEAR, OP_LOAD: state_next = S_RESP;
                    OP_PRODUCT:                 state_next = row_ok ? S_FILL : S_RESP;
                    default:                    state_next = (row_ok && col_ok) ? S_FILL : S_RESP;
                endcase
            end
            S_FILL:
            begin
                state_next = (op_reg == OP_APPEND) ? S_APPEND : S_SCAN;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_HIT;
                end
                else if (!issue && pipe_empty)
                begin
                    unique case (op_reg)
                        OP_PRODUCT: state_next = S_ROUND;
                        OP_READ:    state_next = S_RESP;
                        default:    state_next = S_APPEND;
                    endcase
                end
            end
            S_HIT, S_APPEND, S_ROUND:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control for each state.
    always_comb
    begin
        row_vld_next   = row_vld_reg;
        vec_vld_next   = vec_vld_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        p1_vld_next    = 1'b0;
        p2_vld_next    = 1'b0;
        p3_vld_next    = 1'b0;
        res_val_next   = res_val_reg;
        res_found_next = res_found_reg;
        res_st_next    = res_st_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        ent_we         = 1'b0;
        ent_waddr      = ent_addr(row_addr, hit_idx_reg[IW-1:0]);
        ent_wval       = val_reg;
        ent_raddr      = ent_addr(row_addr, rd_idx_reg[IW-1:0]);
        fill_we        = 1'b0;
        vec_we         = 1'b0;
        load_out       = 1'b0;
        mac_ctrl       = '0;
        unique case (state_reg)
            S_START:
            begin
                res_val_next   = '0;
                res_found_next = 1'b0;
                res_st_next    = ST_OK;
                unique case (op_reg)
                    OP_NONE:
                    begin
                        res_st_next = ST_RANGE;
                    end
                    OP_CLEAR:
                    begin
                        row_vld_next = '0;
                    end
                    OP_LOAD:
                    begin
                        if (col_ok)
                        begin
                            vec_we                 = 1'b1;
                            vec_vld_next[col_addr] = 1'b1;
                            res_val_next           = val_reg;
                        end
                        else
                        begin
                            res_st_next = ST_RANGE;
                        end
                    end
                    OP_PRODUCT:
                    begin
                        if (!row_ok)
                        begin
                            res_st_next = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        if (!(row_ok && col_ok))
                        begin
                            res_st_next = ST_RANGE;
                        end
                    end
                endcase
            end
            S_FILL:
            begin
                fill_next    = row_vld_reg[row_addr] ? fill_q_reg : '0;
                rd_idx_next  = '0;
                mac_ctrl.clr = 1'b1;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + FW'(1);
                end
                p1_vld_next     = issue;
                p2_vld_next     = p1_vld_reg && (op_reg == OP_PRODUCT);
                p3_vld_next     = p2_vld_reg;
                mac_ctrl.mul_en = p2_vld_reg;
                mac_ctrl.acc_en = p3_vld_reg;
            end
            S_HIT:
            begin
                res_found_next = 1'b1;
                unique case (op_reg)
                    OP_OVERWRITE:
                    begin
                        ent_we       = 1'b1;
                        res_val_next = val_reg;
                    end
                    OP_ACCUMULATE:
                    begin
                        ent_we       = 1'b1;
                        ent_wval     = sat_sum;
                        res_val_next = sat_sum;
                    end
                    default:
                    begin
                        res_val_next = hit_val_reg;
                    end
                endcase
            end
            S_APPEND:
            begin
                if (fill_reg >= FW'(EPR))
                begin
                    res_st_next = ST_FULL;
                end
                else
                begin
                    ent_we                = 1'b1;
                    ent_waddr             = ent_addr(row_addr, fill_reg[IW-1:0]);
                    fill_we               = 1'b1;
                    row_vld_next[row_addr] = 1'b1;
                    res_val_next          = val_reg;
                end
            end
            S_ROUND:
            begin
                res_val_next = mac_result;
                res_st_next  = mac_sat ? ST_SAT : ST_OK;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    load_out     = 1'b1;
                    out_vld_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= 9'd256;
            col_count_reg <= 9'd256;
            row_vld_reg   <= '0;
            vec_vld_reg   <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            p3_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_vld_reg <= row_vld_next;
            vec_vld_reg <= vec_vld_next;
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            p1_vld_reg  <= p1_vld_next;
            p2_vld_reg  <= p2_vld_next;
            p3_vld_reg  <= p3_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_ROW_COUNT: row_count_reg <= cfg_data;
                    REG_COL_COUNT: col_count_reg <= cfg_data;
                    default:       row_count_reg <= row_count_reg;
                endcase
            end
        end
    end

    // Payload registers and memories.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= op_t'(s_tuser);
            row_reg <= s_tdata[7:0];
            col_reg <= s_tdata[15:8];
            val_reg <= s_tdata[47:16];
        end
        res_val_reg   <= res_val_next;
        res_found_reg <= res_found_next;
        res_st_reg    <= res_st_next;
        if (load_out)
        begin
            out_val_reg   <= res_val_reg;
            out_found_reg <= res_found_reg;
            out_st_reg    <= res_st_reg;
        end
        fill_q_reg <= fill_mem[row_addr];
        if (fill_we)
        begin
            fill_mem[row_addr] <= fill_reg + FW'(1);
        end
        vec_q_reg  <= vec_mem[ecol_addr];
        vec_ok_reg <= ecol_in && vec_vld_reg[ecol_addr];
        if (vec_we)
        begin
            vec_mem[col_addr] <= val_reg;
        end
        ent_col_q_reg <= ent_col_mem[ent_raddr];
        ent_val_q_reg <= ent_val_mem[ent_raddr];
        if (ent_we)
        begin
            ent_col_mem[ent_waddr] <= col_reg;
            ent_val_mem[ent_waddr] <= ent_wval;
        end
        p1_idx_reg <= rd_idx_reg;
        p2_val_reg <= ent_val_q_reg;
        if (hit)
        begin
            hit_idx_reg <= p1_idx_reg;
            hit_val_reg <= ent_val_q_reg;
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_st_reg == ST_RANGE || out_st_reg == ST_FULL)
        |-> (out_val_reg == '0) && !out_found_reg)
        else $error("error result carries a value");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_found_reg |-> (out_st_reg == ST_OK))
        else $error("matched entry with nonzero status");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> (state_reg == S_START))
        else $error("accepted beat did not start an operation");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_idx_reg <= fill_reg) && (fill_reg <= FW'(EPR)))
        else $error("scan index beyond row fill");
`endif

endmodule
